/* sv/apsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path core.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int DIST_W   = 30;
    localparam int NODE_W   = 7;
    localparam int WEIGHT_W = 16;
    localparam int CNT_W    = 8;
    localparam int PADDR_W  = 3;

    localparam logic [DIST_W-1:0] UNREACH_DIST    = 30'd1000000000;
    localparam logic [CNT_W-1:0]  NODE_COUNT_RST  = 8'd128;
    localparam logic              REG_NODE_COUNT  = 1'b0;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_RUN      = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_QUERY_RD,
        S_QUERY_WT,
        S_ROW_RD,
        S_ROW_WT,
        S_COL,
        S_DRAIN,
        S_FINISH
    } state_t;

endpackage
`default_nettype wire

/* sv/apsp_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_mem
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module apsp_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 30
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    output logic      [DW-1:0] rdata_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_a_reg;
    logic [DW-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

/* sv/apsp_relax.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_relax
// One relaxation step: min(d_ij, d_ik + d_kj), sum saturated at unreachable.
// ----------------------------------------------------------------------------
module apsp_relax
    import apsp_pkg::*;
(
    input  wire logic [DIST_W-1:0] d_ik,
    input  wire logic [DIST_W-1:0] d_kj,
    input  wire logic [DIST_W-1:0] d_ij,
    output logic      [DIST_W-1:0] d_new
);

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] via;

    assign sum   = {1'b0, d_ik} + {1'b0, d_kj};
    assign via   = (sum > {1'b0, UNREACH_DIST}) ? UNREACH_DIST : sum[DIST_W-1:0];
    assign d_new = (via < d_ij) ? via : d_ij;

endmodule
`default_nettype wire

/* sv/all_pairs_shortest_path_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// Floyd-Warshall distance matrix with edge load, closure, query and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// one result, shown for a single cycle with done high, and the receiver cannot
// hold it off. Busy stays high while a request is worked on. Clear, like the
// sweep after reset, rewrites the whole matrix; a run covers the first n nodes,
// n being node_count limited to MAX_NODES: each (k,i) row pass reads d[i][k],
// captures it, streams the row through the two read ports and the write port
// of the matrix store, and ends with a drain write. After reset busy is high
// during the sweep; register writes are taken meanwhile. Distances of
// 1000000000 mean unreachable.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          operation,
    input  wire logic [NODE_W-1:0]   node_from,
    input  wire logic [NODE_W-1:0]   node_to,
    input  wire logic [WEIGHT_W-1:0] weight,
    output logic                     done,
    output logic [DIST_W-1:0]        distance,
    output logic                     unreachable,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = NW + NODE_W;
    localparam int XW    = $clog2(MAX_NODES + 1) + CNT_W;
    localparam logic [NW-1:0] NODE_LAST = NW'(MAX_NODES - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r,
                                                input logic [NW-1:0] c);
        return AW'(r) * AW'(MAX_NODES) + AW'(c);
    endfunction

    state_t               state_reg, state_next;
    op_t                  op_in;
    logic [NW-1:0]        from_reg, to_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic                 inrange_reg;
    logic [NW-1:0]        k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [NW-1:0]        pj_reg, pj_next;
    logic                 pend_reg, pend_next;
    logic                 report_reg, report_next;
    logic [NW-1:0]        nlast_reg;
    logic [DIST_W-1:0]    ik_reg;
    logic [CNT_W-1:0]     node_count_reg;
    logic                 done_reg, done_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic                 unr_reg, unr_next;

    logic [EW-1:0]        from_ext, to_ext;
    logic                 in_range;
    logic [XW-1:0]        cnt_ext, n_clamp, n_m1;
    logic                 accept;
    logic                 cfg_write;

    logic                 mem_we;
    logic [NW-1:0]        w_row, w_col, a_row, a_col, b_row, b_col;
    logic [DIST_W-1:0]    mem_wdata, rdata_a, rdata_b, relax_out, q_dist;

    assign from_ext = EW'(node_from);
    assign to_ext   = EW'(node_to);
    assign in_range = (from_ext < EW'(MAX_NODES)) && (to_ext < EW'(MAX_NODES));
    assign cnt_ext  = XW'(node_count_reg);
    assign n_clamp  = (cnt_ext > XW'(MAX_NODES)) ? XW'(MAX_NODES) : cnt_ext;
    assign n_m1     = n_clamp - XW'(1);
    assign accept   = start && !busy;
    assign op_in    = op_t'(operation);
    assign q_dist   = inrange_reg ? rdata_a : UNREACH_DIST;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ? {24'd0, node_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_write && (paddr[2] == REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    apsp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DIST_W)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (cell_addr(w_row, w_col)),
        .wdata   (mem_wdata),
        .raddr_a (cell_addr(a_row, a_col)),
        .rdata_a (rdata_a),
        .raddr_b (cell_addr(b_row, b_col)),
        .rdata_b (rdata_b)
    );

    apsp_relax u_relax (
        .d_ik  (ik_reg),
        .d_kj  (rdata_b),
        .d_ij  (rdata_a),
        .d_new (relax_out)
    );

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pj_next     = pj_reg;
        pend_next   = 1'b0;
        report_next = report_reg;
        done_next   = 1'b0;
        dist_next   = '0;
        unr_next    = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = relax_out;
        w_row       = i_reg;
        w_col       = pj_reg;
        a_row       = i_reg;
        a_col       = j_reg;
        b_row       = k_reg;
        b_col       = j_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                w_col     = j_reg;
                mem_wdata = (i_reg == j_reg) ? '0 : UNREACH_DIST;
                if (j_reg == NODE_LAST)
                begin
                    j_next = '0;
                    if (i_reg == NODE_LAST)
                    begin
                        i_next     = '0;
                        done_next  = report_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_in)
                        OP_ADD_EDGE: state_next = S_EDGE_A;
                        OP_QUERY:    state_next = S_QUERY_RD;
                        OP_RUN:
                        begin
                            k_next     = '0;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = (node_count_reg == '0) ? S_FINISH : S_ROW_RD;
                        end
                        OP_CLEAR:
                        begin
                            i_next      = '0;
                            j_next      = '0;
                            report_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                    endcase
                end
            end
            S_EDGE_A:
            begin
                mem_we     = inrange_reg;
                w_row      = from_reg;
                w_col      = to_reg;
                mem_wdata  = DIST_W'(weight_reg);
                state_next = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                mem_we     = inrange_reg;
                w_row      = to_reg;
                w_col      = from_reg;
                mem_wdata  = DIST_W'(weight_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_QUERY_RD:
            begin
                a_row      = from_reg;
                a_col      = to_reg;
                state_next = S_QUERY_WT;
            end
            S_QUERY_WT:
            begin
                dist_next  = q_dist;
                unr_next   = (q_dist >= UNREACH_DIST);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_ROW_RD:
            begin
                a_col      = k_reg;
                state_next = S_ROW_WT;
            end
            S_ROW_WT:
            begin
                j_next     = '0;
                state_next = S_COL;
            end
            S_COL:
            begin
                // write-back of column pj overlaps the read of column j
                mem_we    = pend_reg;
                pend_next = 1'b1;
                pj_next   = j_reg;
                if (j_reg == nlast_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                end
            end
            S_DRAIN:
            begin
                mem_we = pend_reg;
                if (i_reg == nlast_reg)
                begin
                    i_next = '0;
                    if (k_reg == nlast_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        k_next     = k_reg + NW'(1);
                        state_next = S_ROW_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = S_ROW_RD;
                end
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            pj_reg     <= '0;
            pend_reg   <= 1'b0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
            dist_reg   <= '0;
            unr_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            pj_reg     <= pj_next;
            pend_reg   <= pend_next;
            report_reg <= report_next;
            done_reg   <= done_next;
            dist_reg   <= dist_next;
            unr_reg    <= unr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_reg    <= from_ext[NW-1:0];
            to_reg      <= to_ext[NW-1:0];
            weight_reg  <= weight;
            inrange_reg <= in_range;
            nlast_reg   <= n_m1[NW-1:0];
        end
        if (state_reg == S_ROW_WT)
        begin
            ik_reg <= rdata_a;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign distance    = dist_reg;
    assign unreachable = unr_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken without going busy");
    a_unreach_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (unreachable == (distance == UNREACH_DIST)))
        else $error("unreachable flag disagrees with distance");
    a_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ((distance == '0) && !unreachable))
        else $error("result ports not quiet between results");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the all-pairs shortest path core.
// A queue of requests feeds a clocked driver, which holds start until the core
// takes each request and updates a local distance-matrix predictor at that
// point. A clocked monitor checks every done strobe against the oldest
// predicted result. The node count register is set over APB only while the
// core is idle. A short directed part comes first, then random batches of
// edge loads, closures, queries and occasional clears over small graphs.
// ----------------------------------------------------------------------------
module tb;
    import apsp_pkg::*;

    localparam int MAX_N        = 128;
    localparam int LIMIT_CYCLES = 15_000_000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int REG_SPARE    = 1;

    typedef struct {
        op_t                 op;
        logic [NODE_W-1:0]   from;
        logic [NODE_W-1:0]   to;
        logic [WEIGHT_W-1:0] weight;
        bit                  drain_first;
    } req_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              unreachable;
    } dist_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic [1:0]          operation = OP_ADD_EDGE;
    logic [NODE_W-1:0]   node_from = '0;
    logic [NODE_W-1:0]   node_to   = '0;
    logic [WEIGHT_W-1:0] weight    = '0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic                busy;
    logic                done;
    logic [DIST_W-1:0]   distance;
    logic                unreachable;
    logic [31:0]         prdata;
    logic                pready;

    all_pairs_shortest_path_core #(
        .MAX_NODES (MAX_N)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .node_from   (node_from),
        .node_to     (node_to),
        .weight      (weight),
        .done        (done),
        .distance    (distance),
        .unreachable (unreachable),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [DIST_W-1:0] dist_model [MAX_N*MAX_N];
    logic [CNT_W-1:0]  model_node_count;

    req_t         pending_reqs[$];
    dist_result_t expected_dists[$];
    req_t         active_req;
    int           idle_left     = 0;
    int           steady_left   = 0;
    int           mismatch_count = 0;
    int           cycle_count   = 0;
    int           random_count  = 0;

    function automatic void clear_model();
        for (int r = 0; r < MAX_N; r++)
        begin
            for (int c = 0; c < MAX_N; c++)
            begin
                dist_model[r*MAX_N + c] = (r == c) ? '0 : UNREACH_DIST;
            end
        end
    endfunction

    function automatic void close_model();
        int         n;
        logic [30:0] via;
        n = (model_node_count > MAX_N) ? MAX_N : int'(model_node_count);
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    via = {1'b0, dist_model[i*MAX_N + k]} + {1'b0, dist_model[k*MAX_N + j]};
                    if (via > {1'b0, UNREACH_DIST})
                        via = {1'b0, UNREACH_DIST};
                    if (via < {1'b0, dist_model[i*MAX_N + j]})
                        dist_model[i*MAX_N + j] = via[DIST_W-1:0];
                end
            end
        end
    endfunction

    function automatic void predict_request(req_t r);
        dist_result_t res;
        res.distance    = '0;
        res.unreachable = 1'b0;
        case (r.op)
            OP_ADD_EDGE:
            begin
                dist_model[int'(r.from)*MAX_N + int'(r.to)] = DIST_W'(r.weight);
                dist_model[int'(r.to)*MAX_N + int'(r.from)] = DIST_W'(r.weight);
            end
            OP_RUN:
                close_model();
            OP_QUERY:
            begin
                res.distance    = dist_model[int'(r.from)*MAX_N + int'(r.to)];
                res.unreachable = (res.distance >= UNREACH_DIST);
            end
            default:
                clear_model();
        endcase
        expected_dists.insert(expected_dists.size(), res);
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s expected %0d got %0d", what, want, got);
    endfunction

    // driver
    always @(posedge clk)
    begin
        bit taken;
        bit issue;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            issue = 1'b0;
            if (taken)
            begin
                predict_request(active_req);
                idle_left = pick_gap();
            end
            if (!start || taken)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_reqs.size() != 0)
                begin
                    if (!pending_reqs[0].drain_first ||
                        (!taken && !busy && expected_dists.size() == 0))
                    begin
                        issue      = 1'b1;
                        active_req = pending_reqs.pop_front();
                    end
                end
                start <= issue;
                if (issue)
                begin
                    operation <= active_req.op;
                    node_from <= active_req.from;
                    node_to   <= active_req.to;
                    weight    <= active_req.weight;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dist_result_t want;
        if (rst_n && done)
        begin
            if (expected_dists.size() == 0)
            begin
                report_mismatch("unexpected result, distance", 32'd0, 32'(distance));
            end
            else
            begin
                want = expected_dists.pop_front();
                if (distance !== want.distance)
                    report_mismatch("distance", 32'(want.distance), 32'(distance));
                if (unreachable !== want.unreachable)
                    report_mismatch("unreachable", 32'(want.unreachable), 32'(unreachable));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_req(op_t op, int from, int to, int w, bit drain);
        req_t r;
        r.op          = op;
        r.from        = NODE_W'(from);
        r.to          = NODE_W'(to);
        r.weight      = WEIGHT_W'(w);
        r.drain_first = drain;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_dists.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_NODE_COUNT))
        begin
            model_node_count = value[CNT_W-1:0];
            // read back
            @(posedge clk);
            psel <= 1'b1;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata !== 32'(value[CNT_W-1:0]))
                report_mismatch("node_count readback", 32'(value[CNT_W-1:0]), prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic int pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 10)
            return 16'hFFFF;
        if (r < 55)
            return $urandom_range(1, 20);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    task automatic push_noise();
        push_req(op_t'($urandom_range(0, 2)), $urandom_range(0, MAX_N-1),
                 $urandom_range(0, MAX_N-1), $urandom_range(0, 16'hFFFF), 1'b0);
        random_count++;
    endtask

    task automatic push_batch(int n);
        int rounds;
        int cnt;
        rounds = $urandom_range(1, 3);
        if ($urandom_range(0, 99) < 15)
        begin
            push_req(OP_CLEAR, $urandom_range(0, MAX_N-1), $urandom_range(0, MAX_N-1),
                     $urandom_range(0, 16'hFFFF), 1'b0);
            random_count++;
        end
        for (int rd = 0; rd < rounds; rd++)
        begin
            cnt = $urandom_range(1, 2*n + 2);
            for (int e = 0; e < cnt; e++)
            begin
                push_req(OP_ADD_EDGE, $urandom_range(0, n-1), $urandom_range(0, n-1),
                         pick_weight(), 1'b0);
                random_count++;
                if ($urandom_range(0, 99) < 15)
                    push_noise();
            end
            push_req(OP_RUN, $urandom_range(0, MAX_N-1), $urandom_range(0, MAX_N-1),
                     $urandom_range(0, 16'hFFFF), $urandom_range(0, 99) < 10);
            random_count++;
            cnt = $urandom_range(3, 12);
            for (int q = 0; q < cnt; q++)
            begin
                push_req(OP_QUERY, $urandom_range(0, n-1), $urandom_range(0, n-1),
                         $urandom_range(0, 16'hFFFF), 1'b0);
                random_count++;
                if ($urandom_range(0, 99) < 15)
                    push_noise();
            end
        end
    endtask

    initial
    begin
        int n;
        clear_model();
        model_node_count = NODE_COUNT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents under the reset node count
        push_req(OP_QUERY, 0, 0, 16'hFFFF, 1'b0);
        push_req(OP_QUERY, 0, 127, 0, 1'b0);
        push_req(OP_QUERY, 127, 127, 0, 1'b0);
        wait_idle();

        write_reg(int'(REG_NODE_COUNT), 32'd4);
        push_req(OP_ADD_EDGE, 0, 1, 5, 1'b0);
        push_req(OP_ADD_EDGE, 1, 2, 16'hFFFF, 1'b0);
        push_req(OP_ADD_EDGE, 2, 3, 0, 1'b0);
        push_req(OP_ADD_EDGE, 127, 126, 16'hFFFF, 1'b0);   // outside node count
        push_req(OP_ADD_EDGE, 3, 3, 7, 1'b0);              // self loop
        push_req(OP_ADD_EDGE, 0, 1, 9, 1'b0);              // overwrite
        push_req(OP_ADD_EDGE, 0, 3, 16'hFFFF, 1'b0);
        push_req(OP_RUN, 127, 127, 16'hFFFF, 1'b1);
        push_req(OP_QUERY, 0, 2, 0, 1'b0);
        push_req(OP_QUERY, 2, 0, 0, 1'b0);
        push_req(OP_QUERY, 3, 3, 0, 1'b0);
        push_req(OP_QUERY, 0, 3, 0, 1'b0);
        push_req(OP_QUERY, 127, 126, 0, 1'b0);
        push_req(OP_QUERY, 0, 127, 0, 1'b0);
        push_req(OP_CLEAR, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 0, 1, 0, 1'b0);
        push_req(OP_QUERY, 127, 126, 0, 1'b0);
        wait_idle();

        // write to an unused index must leave node_count alone
        write_reg(REG_SPARE, 32'd2);
        push_req(OP_ADD_EDGE, 0, 1, 1, 1'b0);
        push_req(OP_ADD_EDGE, 1, 2, 1, 1'b0);
        push_req(OP_ADD_EDGE, 2, 3, 1, 1'b0);
        push_req(OP_RUN, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 0, 3, 0, 1'b0);
        wait_idle();

        write_reg(int'(REG_NODE_COUNT), 32'd0);
        push_req(OP_ADD_EDGE, 4, 5, 3, 1'b0);
        push_req(OP_ADD_EDGE, 5, 6, 4, 1'b0);
        push_req(OP_RUN, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 4, 6, 0, 1'b0);
        wait_idle();

        write_reg(int'(REG_NODE_COUNT), 32'd1);
        push_req(OP_ADD_EDGE, 0, 0, 9, 1'b0);
        push_req(OP_RUN, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 4, 6, 0, 1'b0);
        wait_idle();

        write_reg(int'(REG_NODE_COUNT), 32'd128);
        push_req(OP_ADD_EDGE, 0, 127, 1, 1'b0);
        push_req(OP_ADD_EDGE, 127, 64, 2, 1'b0);
        push_req(OP_ADD_EDGE, 64, 5, 3, 1'b0);
        push_req(OP_QUERY, 127, 0, 0, 1'b0);
        wait_idle();

        // count above the matrix size: closure covers every node
        write_reg(int'(REG_NODE_COUNT), 32'd255);
        push_req(OP_RUN, 0, 0, 0, 1'b0);
        push_req(OP_QUERY, 0, 5, 0, 1'b0);
        push_req(OP_QUERY, 5, 0, 0, 1'b0);
        push_req(OP_QUERY, 127, 6, 0, 1'b0);
        push_req(OP_QUERY, 0, 0, 0, 1'b0);
        wait_idle();

        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 10)
                n = 1;
            else if ($urandom_range(0, 99) < 8)
                n = 16;
            else
                n = $urandom_range(2, 12);
            write_reg(int'(REG_NODE_COUNT), 32'(n));
            push_batch(n);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_dists.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* all_pairs_shortest_path_core.f */
sv/apsp_pkg.sv
sv/apsp_mem.sv
sv/apsp_relax.sv
sv/all_pairs_shortest_path_core.sv
sim/tb.sv
